>>> src/u8fnc_pkg.sv
// Shared types, constants and the whitespace helper function for the UTF-8 file-name checker.
package u8fnc_pkg;

  // Verdict codes carried on the result channel.
  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_EMPTY     = 3'd1,
    RSN_DOTS      = 3'd2,
    RSN_MALFORMED = 3'd3,
    RSN_FORBIDDEN = 3'd4,
    RSN_BLANK     = 3'd5
  } reason_t;

  localparam int CpW = 21;

  localparam logic [7:0] ByteNul   = 8'h00;
  localparam logic [7:0] ByteDot   = 8'h2E;
  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [7:0] ByteBslsh = 8'h5C;
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Lo   = 8'hE0;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] Lead4Lo   = 8'hF0;
  localparam logic [7:0] Lead4Hi   = 8'hF4;
  localparam logic [7:0] LeadSurr  = 8'hED;

  // Per-name scan state, carried between items.
  typedef struct packed {
    logic [1:0]     pend;        // continuation bytes still expected
    logic [CpW-1:0] cp;          // codepoint assembled so far
    logic [7:0]     lead;        // lead byte of the open sequence
    logic           second_due;  // next byte is the range-checked second byte
    logic [1:0]     seen;        // byte count, saturating at three
    logic           all_dots;
    logic           visible;
    reason_t        err;         // first error, sticky
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    pend:       2'd0,
    cp:         '0,
    lead:       8'd0,
    second_due: 1'b0,
    seen:       2'd0,
    all_dots:   1'b1,
    visible:    1'b0,
    err:        RSN_OK
  };

  // Unicode whitespace set, plus the C0 control codepoints, used for the blank-name test.
  function automatic logic is_space_cp(input logic [CpW-1:0] cp);
    is_space_cp = (cp <= 21'h20) || (cp == 21'h85) || (cp == 21'hA0) ||
                  (cp == 21'h1680) || (cp >= 21'h2000 && cp <= 21'h200A) ||
                  (cp == 21'h2028) || (cp == 21'h2029) || (cp == 21'h202F) ||
                  (cp == 21'h205F) || (cp == 21'h3000);
  endfunction

endpackage

>>> src/u8fnc_step.sv
// Combinational next-state and verdict logic for one name byte.
module u8fnc_step (
  input  u8fnc_pkg::scan_state_t st,
  input  logic [7:0]             name_byte,
  input  logic                   is_last,
  input  logic                   is_empty,
  output u8fnc_pkg::scan_state_t st_nxt,
  output logic                   emit,
  output u8fnc_pkg::reason_t     reason
);
  import u8fnc_pkg::*;

  scan_state_t    tk;
  logic [CpW-1:0] cp_ext;
  logic           bad_second;

  assign cp_ext = {st.cp[CpW-7:0], name_byte[5:0]};

  // The second byte of some sequences has a narrowed range: this rules out
  // overlong three- and four-byte forms, surrogates and codepoints past the
  // Unicode limit.
  assign bad_second = (st.lead == Lead3Lo  && name_byte < 8'hA0) ||
                      (st.lead == LeadSurr && name_byte >= 8'hA0) ||
                      (st.lead == Lead4Lo  && name_byte < 8'h90) ||
                      (st.lead == Lead4Hi  && name_byte >= 8'h90);

  always_comb begin
    tk = st;
    if (!is_empty) begin
      if (st.seen != 2'd3) begin
        tk.seen = st.seen + 2'd1;
      end
      if (name_byte != ByteDot) begin
        tk.all_dots = 1'b0;
      end
      if (st.err == RSN_OK) begin
        if (st.pend == 2'd0) begin
          if (!name_byte[7]) begin
            if (name_byte == ByteNul || name_byte == ByteSlash || name_byte == ByteBslsh) begin
              tk.err = RSN_FORBIDDEN;
            end else if (!is_space_cp({13'd0, name_byte})) begin
              tk.visible = 1'b1;
            end
          end else if (name_byte >= Lead2Lo && name_byte <= Lead2Hi) begin
            tk.pend       = 2'd1;
            tk.cp         = {16'd0, name_byte[4:0]};
            tk.lead       = name_byte;
            tk.second_due = 1'b1;
          end else if (name_byte >= Lead3Lo && name_byte <= Lead3Hi) begin
            tk.pend       = 2'd2;
            tk.cp         = {17'd0, name_byte[3:0]};
            tk.lead       = name_byte;
            tk.second_due = 1'b1;
          end else if (name_byte >= Lead4Lo && name_byte <= Lead4Hi) begin
            tk.pend       = 2'd3;
            tk.cp         = {18'd0, name_byte[2:0]};
            tk.lead       = name_byte;
            tk.second_due = 1'b1;
          end else begin
            tk.err = RSN_MALFORMED;
          end
        end else if (name_byte[7:6] != 2'b10) begin
          tk.err = RSN_MALFORMED;
        end else if (st.second_due && bad_second) begin
          tk.second_due = 1'b0;
          tk.err        = RSN_MALFORMED;
        end else begin
          tk.second_due = 1'b0;
          tk.cp         = cp_ext;
          tk.pend       = st.pend - 2'd1;
          if (st.pend == 2'd1 && !is_space_cp(cp_ext)) begin
            tk.visible = 1'b1;
          end
        end
      end
    end

    emit = is_empty || is_last;

    if (tk.seen == 2'd0) begin
      reason = RSN_EMPTY;
    end else if (tk.all_dots && tk.seen <= 2'd2) begin
      reason = RSN_DOTS;
    end else if (tk.err != RSN_OK) begin
      reason = tk.err;
    end else if (tk.pend != 2'd0) begin
      reason = RSN_MALFORMED;
    end else if (!tk.visible) begin
      reason = RSN_BLANK;
    end else begin
      reason = RSN_OK;
    end

    // A closed name leaves the scanner clean for the next one.
    st_nxt = emit ? ScanReset : tk;
  end

endmodule

>>> src/utf8_file_name_checker.sv
// Top level of the strict UTF-8 file-name component checker.
//
//  Channel  | Ports                               | Contents
//  ---------+-------------------------------------+-----------------------------------
//  input    | in_tvalid in_tready in_tdata        | one name byte per item,
//           | in_tlast in_tuser                   | tlast = last byte, tuser = empty
//  result   | out_tvalid out_tready out_tdata     | one verdict per closed name
//
// Throughput is one byte per clock while no closing byte waits on a stalled result.
// The item that closes a name is held in the input register, where u8fnc_step judges it;
// its verdict is then registered in the result register and offered on the result channel.
// The loop that limits the clock is the scan state feedback through u8fnc_step.
// Reset (rst_n low, synchronous) empties both stages and clears the scan state.
// A stalled result holds in the result register; the input stage keeps taking
// bytes that produce no verdict, and stalls only when a second verdict is ready.
module utf8_file_name_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] name_byte
  input  logic       in_tlast,   // is_last
  input  logic       in_tuser,   // [0] is_empty
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] name_ok, [3:1] reject_reason, [7:4] zero
);
  import u8fnc_pkg::*;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  // Scan state for the name in progress.
  scan_state_t st_r;
  scan_state_t st_nxt;

  // Result register stage.
  logic    out_valid_r;
  logic    out_ok_r;
  reason_t out_reason_r;

  logic    step_emit;
  reason_t step_reason;
  logic    out_free;
  logic    s1_advance;

  u8fnc_step u_step (
    .st        (st_r),
    .name_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .is_empty  (s1_empty_r),
    .st_nxt    (st_nxt),
    .emit      (step_emit),
    .reason    (step_reason)
  );

  // The held byte moves on unless it closes a name while the previous verdict
  // is still waiting to be taken.
  assign out_free   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && (!step_emit || out_free);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_last_r  <= in_tlast;
      s1_empty_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ScanReset;
    end else if (s1_advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && step_emit) begin
      out_ok_r     <= (step_reason == RSN_OK);
      out_reason_r <= step_reason;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_reason_r, out_ok_r};

endmodule

>>> src/u8fnc_checker.sv
// Port-level assertions for the file-name checker and their binding.
module u8fnc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import u8fnc_pkg::*;

  // A pending verdict stays offered with the same contents until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict dropped or changed while stalled");

  // The ok flag agrees with the reason code.
  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == RSN_OK)))
    else $error("name_ok disagrees with reject_reason");

  // Only defined reason codes leave the block, with zero padding.
  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:1] <= RSN_BLANK) && (out_tdata[7:4] == 4'd0))
    else $error("undefined reason code on the result channel");

  // A fresh verdict always follows a closing item that entered through the input handshake.
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && (in_tlast || in_tuser), 2))
    else $error("verdict without a closing item two cycles earlier");

endmodule

bind utf8_file_name_checker u8fnc_checker u_u8fnc_checker (.*);

>>> test/utf8_file_name_checker_test.sv
// Self-checking testbench for the strict UTF-8 file-name component checker.
`timescale 1ns / 1ps

module utf8_file_name_checker_test;
  import u8fnc_pkg::*;

  typedef struct packed {
    logic    ok;
    reason_t why;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  utf8_file_name_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Predicted scan state of the name currently streaming in.
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic [7:0]  seq_lead;
  logic        check_second;
  logic [1:0]  byte_count;
  logic        only_dots;
  logic        has_visible;
  reason_t     sticky_err;

  verdict_t    verdicts_due[$];
  logic [7:0]  name_buf[$];
  int          ins_pos;

  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_left = 0;
  int items_sent = 0;
  int verdicts_checked = 0;
  int errors = 0;
  int reason_hits[6] = '{default: 0};

  function automatic logic is_blank_cp(input logic [20:0] cp);
    return cp inside {[21'h0 : 21'h20], 21'h85, 21'hA0, 21'h1680,
                      [21'h2000 : 21'h200A], 21'h2028, 21'h2029, 21'h202F,
                      21'h205F, 21'h3000};
  endfunction

  task automatic clear_scan();
    cont_left    = 2'd0;
    cp_acc       = '0;
    seq_lead     = 8'd0;
    check_second = 1'b0;
    byte_count   = 2'd0;
    only_dots    = 1'b1;
    has_visible  = 1'b0;
    sticky_err   = RSN_OK;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    if (byte_count != 2'd3) byte_count++;
    if (b != ByteDot) only_dots = 1'b0;
    // Once an error is latched, bytes only feed the length and dot tracking.
    if (sticky_err != RSN_OK) return;
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        if (b == ByteNul || b == ByteSlash || b == ByteBslsh) sticky_err = RSN_FORBIDDEN;
        else if (!is_blank_cp({13'd0, b})) has_visible = 1'b1;
        return;
      end
      if (b >= Lead2Lo && b <= Lead2Hi) begin
        cont_left = 2'd1;
        cp_acc = {16'd0, b[4:0]};
      end else if (b >= Lead3Lo && b <= Lead3Hi) begin
        cont_left = 2'd2;
        cp_acc = {17'd0, b[3:0]};
      end else if (b >= Lead4Lo && b <= Lead4Hi) begin
        cont_left = 2'd3;
        cp_acc = {18'd0, b[2:0]};
      end else begin
        sticky_err = RSN_MALFORMED;
        return;
      end
      seq_lead = b;
      check_second = 1'b1;
      return;
    end
    // A forbidden byte here is simply not a continuation byte.
    if (b[7:6] != 2'b10) begin
      sticky_err = RSN_MALFORMED;
      return;
    end
    if (check_second) begin
      check_second = 1'b0;
      if ((seq_lead == Lead3Lo && b < 8'hA0) || (seq_lead == LeadSurr && b >= 8'hA0) ||
          (seq_lead == Lead4Lo && b < 8'h90) || (seq_lead == Lead4Hi && b >= 8'h90)) begin
        sticky_err = RSN_MALFORMED;
        return;
      end
    end
    cp_acc = {cp_acc[14:0], b[5:0]};
    cont_left--;
    if (cont_left == 2'd0 && !is_blank_cp(cp_acc)) has_visible = 1'b1;
  endtask

  function automatic reason_t name_verdict();
    if (byte_count == 2'd0) return RSN_EMPTY;
    if (only_dots && byte_count <= 2'd2) return RSN_DOTS;
    if (sticky_err != RSN_OK) return sticky_err;
    if (cont_left != 2'd0) return RSN_MALFORMED;
    if (!has_visible) return RSN_BLANK;
    return RSN_OK;
  endfunction

  task automatic predict_item(input logic [7:0] b, input logic last, input logic empty);
    verdict_t v;
    if (!empty) begin
      scan_byte(b);
      if (!last) return;
    end
    v.why = name_verdict();
    v.ok = (v.why == RSN_OK);
    verdicts_due.push_back(v);
    clear_scan();
  endtask

  // Offers one item, with a possible random idle gap first, and predicts it on acceptance.
  task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
    if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tuser  <= empty;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_item(b, last, empty);
    items_sent++;
  endtask

  task automatic send_name(input bit close_by_empty);
    for (int i = 0; i < name_buf.size(); i++)
      send_item(name_buf[i], (i == name_buf.size() - 1) && !close_by_empty, 1'b0);
    if (close_by_empty || name_buf.size() == 0)
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic wait_for_verdicts();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      name_buf.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      name_buf.push_back({3'b110, cp[10:6]});
      name_buf.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      name_buf.push_back({4'b1110, cp[15:12]});
      name_buf.push_back({2'b10, cp[11:6]});
      name_buf.push_back({2'b10, cp[5:0]});
    end else begin
      name_buf.push_back({5'b11110, cp[20:18]});
      name_buf.push_back({2'b10, cp[17:12]});
      name_buf.push_back({2'b10, cp[11:6]});
      name_buf.push_back({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [20:0] pick_blank_cp();
    case ($urandom_range(8))
      0: return 21'($urandom_range(32));
      1: return 21'h20;
      2: return 21'h85;
      3: return 21'hA0;
      4: return 21'h1680;
      5: return 21'h2000 + 21'($urandom_range(10));
      6: return $urandom_range(1) ? 21'h2028 : 21'h2029;
      7: return $urandom_range(1) ? 21'h202F : 21'h205F;
      default: return 21'h3000;
    endcase
  endfunction

  function automatic logic [20:0] pick_cp(input bit mostly_blank);
    logic [20:0] cp;
    if (mostly_blank && $urandom_range(3) != 0) return pick_blank_cp();
    case ($urandom_range(9))
      0, 1: cp = 21'($urandom_range(8'h20, 8'h7F));
      2: cp = 21'($urandom_range(8'h20));
      3: cp = pick_blank_cp();
      4: cp = 21'($urandom_range(12'h80, 12'h7FF));
      5: begin
        cp = 21'($urandom_range(16'h800, 16'hFFFF));
        // Step down out of the surrogate range.
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      end
      6: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      7: case ($urandom_range(7))
        0: cp = 21'h7F;
        1: cp = 21'h80;
        2: cp = 21'h7FF;
        3: cp = 21'h800;
        4: cp = 21'hD7FF;
        5: cp = 21'hE000;
        6: cp = 21'h10000;
        default: cp = 21'h10FFFF;
      endcase
      default: cp = 21'($urandom_range(8'h61, 8'h7A));
    endcase
    return cp;
  endfunction

  task automatic splice(input logic [7:0] b);
    name_buf.insert(ins_pos, b);
    ins_pos++;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Damages an otherwise well-formed name, mostly in ways strict UTF-8 or the name rules reject.
  task automatic damage_name();
    ins_pos = $urandom_range(name_buf.size());
    case ($urandom_range(7))
      0: if (name_buf.size() != 0)
        name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(255));
      1: if (name_buf.size() != 0) void'(name_buf.pop_back());
      2: splice(cont_byte());
      3: case ($urandom_range(2))
        0: begin
          splice(8'hC0 | 8'($urandom_range(1)));
          splice(cont_byte());
        end
        1: begin
          splice(Lead3Lo);
          splice(8'h80 + 8'($urandom_range(31)));
          splice(cont_byte());
        end
        default: begin
          splice(Lead4Lo);
          splice(8'h80 + 8'($urandom_range(15)));
          splice(cont_byte());
          splice(cont_byte());
        end
      endcase
      4: begin
        splice(LeadSurr);
        splice(8'hA0 + 8'($urandom_range(31)));
        splice(cont_byte());
      end
      5: if ($urandom_range(1)) begin
        splice(Lead4Hi);
        splice(8'h90 + 8'($urandom_range(47)));
        splice(cont_byte());
        splice(cont_byte());
      end else begin
        splice(8'hF5 + 8'($urandom_range(10)));
      end
      6: case ($urandom_range(2))
        0: splice(ByteNul);
        1: splice(ByteSlash);
        default: splice(ByteBslsh);
      endcase
      default: begin
        splice(Lead2Lo + 8'($urandom_range(8'h32)));
        splice(8'h41);
      end
    endcase
  endtask

  // Builds one random name in name_buf; returns whether it closes with an empty item.
  task automatic make_random_name(output bit close_by_empty);
    int kind;
    int n;
    name_buf.delete();
    close_by_empty = 1'b0;
    kind = $urandom_range(99);
    if (kind < 4) begin
      close_by_empty = 1'b1;
    end else if (kind < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) name_buf.push_back(ByteDot);
    end else if (kind < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) name_buf.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) put_code_point(pick_cp(kind >= 90));
      if (kind >= 60 && kind < 90) damage_name();
    end
    if ($urandom_range(99) < 12) close_by_empty = 1'b1;
  endtask

  // Result checking and receiver stalls share one process.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got tdata=%h", $time, out_tdata);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        verdicts_checked++;
        reason_hits[v.why]++;
        if (out_tdata[0] !== v.ok || out_tdata[3:1] !== v.why || out_tdata[7:4] !== 4'd0) begin
          $display("%0t: verdict mismatch, expected ok=%0b reason=%0d, got ok=%b reason=%0d pad=%h",
                   $time, v.ok, v.why, out_tdata[0], out_tdata[3:1], out_tdata[7:4]);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic test_directed_names();
    snd_idle = 0;
    rcv_stall = 0;
    send_item(8'hFF, 1'b1, 1'b1);              // empty flag wins over last
    name_buf = '{ByteDot};
    send_name(1'b0);
    name_buf = '{ByteDot, ByteDot};
    send_name(1'b0);
    name_buf = '{ByteNul};
    send_name(1'b0);
    name_buf = '{8'hFF};
    send_name(1'b0);
    name_buf = '{LeadSurr, 8'hA0, 8'h80};       // surrogate
    send_name(1'b0);
    name_buf = '{Lead3Lo, 8'h9F};               // overlong three-byte form
    send_name(1'b0);
    name_buf = '{Lead4Lo, 8'h8F};               // overlong four-byte form
    send_name(1'b0);
    name_buf = '{Lead4Hi, 8'h90};               // above U+10FFFF
    send_name(1'b0);
    name_buf = '{8'hC3, ByteSlash};             // forbidden byte inside a sequence
    send_name(1'b0);
    name_buf = '{8'hC3};                        // cut off by the end of the name
    send_name(1'b0);
    name_buf = '{8'h20};
    send_name(1'b0);
    name_buf = '{Lead4Hi, 8'h8F, 8'hBF, 8'hBF};   // highest legal codepoint
    send_name(1'b0);
    name_buf = '{8'h61};                        // bytes closed by an empty item
    send_name(1'b1);
    name_buf = '{8'h80, ByteSlash};             // later byte cannot change the reason
    send_name(1'b0);
    wait_for_verdicts();
  endtask

  task automatic test_random_names();
    bit close_by_empty;
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 69; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 69; end
        default: begin snd_idle = 35; rcv_stall = 35; end
      endcase
      target = items_sent + 450;
      while (items_sent < target) begin
        make_random_name(close_by_empty);
        send_name(close_by_empty);
        if ($urandom_range(29) == 0) wait_for_verdicts();
      end
      wait_for_verdicts();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_result_backpressure();
    snd_idle = 0;
    rcv_stall = 0;
    hold_left = 200;
    repeat (40) begin
      name_buf = '{8'($urandom_range(8'h61, 8'h7A))};
      send_name(1'b0);
    end
    wait_for_verdicts();
    rcv_stall = 35;
    repeat (20) begin
      name_buf = '{8'($urandom_range(255)), 8'($urandom_range(255))};
      send_name(1'b0);
    end
    wait_for_verdicts();
  endtask

  initial begin
    clear_scan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_names();
    test_random_names();
    test_result_backpressure();
    wait_for_verdicts();
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0) errors++;
    $display("Sent %0d items and checked %0d verdicts under four idle and stall mixes.",
             items_sent, verdicts_checked);
    $display("Verdicts: ok %0d, empty %0d, dots %0d, malformed %0d, forbidden %0d, blank %0d.",
             reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
             reason_hits[4], reason_hits[5]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
